FILE: sv/adtm_pkg.sv
// Shared types, register indexes and helpers for the frame difference erosion block.
package adtm_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 11;
    localparam int THR_W      = 9;
    localparam int SIZE_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int N_SLOTS    = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 2'd2;

    // Frame size after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd2048;

    // Input beat: one pixel pair
    typedef struct packed {
        logic [PIX_W-1:0] current_pixel;
        logic [PIX_W-1:0] reference_pixel;
    } t_in_beat;

    // Output beat: one eroded pixel with its position
    typedef struct packed {
        logic [PIX_W-1:0]   eroded_diff;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               last_of_run;
    } t_out_beat;

    // Results released by one pixel.
    // Slot 0: row above, column left; slot 1: row above, this column;
    // slot 2: this row, column left;  slot 3: this row, this column.
    typedef struct packed {
        logic [N_SLOTS-1:0]            mask;
        logic [N_SLOTS-1:0][PIX_W-1:0] vals;
        logic [COORD_W-1:0]            row;
        logic [COORD_W-1:0]            col;
    } t_grp;

    function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: sv/adtm_line_mem.sv
// Simple dual-port line memory with registered read data.
module adtm_line_mem #(
    parameter int DEPTH = 2048,
    parameter int DW    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

FILE: sv/adtm_result_queue.sv
// Result group register: holds up to four results of one pixel and sends them one per beat.
module adtm_result_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  adtm_pkg::t_grp      i_grp,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output adtm_pkg::t_out_beat o_out_data
);

    logic [adtm_pkg::N_SLOTS-1:0]                    r_mask;
    logic [adtm_pkg::N_SLOTS-1:0]                    n_mask;
    logic [adtm_pkg::N_SLOTS-1:0][adtm_pkg::PIX_W-1:0] r_vals;
    logic [adtm_pkg::COORD_W-1:0]                    r_row;
    logic [adtm_pkg::COORD_W-1:0]                    r_col;

    logic                          pop;
    logic [adtm_pkg::N_SLOTS-1:0]  rest;
    logic [adtm_pkg::N_SLOTS-1:0]  after_pop;
    logic [1:0]                    slot;

    // Pending slots, oldest is the lowest set bit
    assign pop       = (r_mask != '0) && !i_out_stall;
    assign rest      = r_mask & (r_mask - adtm_pkg::N_SLOTS'(1));
    assign after_pop = pop ? rest : r_mask;
    assign o_free    = (after_pop == '0);
    assign n_mask    = i_load ? i_grp.mask : after_pop;

    always_comb begin
        if (r_mask[0]) begin
            slot = 2'd0;
        end else if (r_mask[1]) begin
            slot = 2'd1;
        end else if (r_mask[2]) begin
            slot = 2'd2;
        end else begin
            slot = 2'd3;
        end
    end

    // Output beat: lower slots are the row above, even slots the column left
    assign o_out_valid            = (r_mask != '0);
    assign o_out_data.eroded_diff = r_vals[slot];
    assign o_out_data.out_row     = slot[1] ? r_row : r_row - adtm_pkg::COORD_W'(1);
    assign o_out_data.out_col     = slot[0] ? r_col : r_col - adtm_pkg::COORD_W'(1);
    assign o_out_data.last_of_run = (rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vals <= i_grp.vals;
            r_row  <= i_grp.row;
            r_col  <= i_grp.col;
        end
    end

    // A new group only lands once the old one has gone out
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result group overwritten before drained");

    // A taken beat that is not the last of its run leaves more behind
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_of_run) |=> o_out_valid)
        else $error("run ended without last_of_run");

    // After the last beat of a run, nothing follows unless a new group was loaded
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_of_run && !i_load)
        |=> !o_out_valid)
        else $error("beat sent after last_of_run");

endmodule

FILE: sv/absdiff_threshold_min3x3_core.sv
// Top level: frame difference, threshold and 3x3 erosion with border replicate.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall     | i_in_data  (pixel pair)
//  out     | output    | o_out_valid / i_out_stall   | o_out_data (eroded pixel)
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One pixel pair per clock unless the output stalls; a result passes stage A and the
// result group register. A pixel releasing several results holds the input until the
// last is taken, one per output beat; that happens at a row end and on the last row.
// Reset clears position, window, threshold and control and sets the frame size to
// 2048 clamped to the maximum; line memory is not cleared.
// i_out_stall reaches o_in_stall combinationally once the result group is occupied.
module absdiff_threshold_min3x3_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  adtm_pkg::t_in_beat                  i_in_data,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output adtm_pkg::t_out_beat                 o_out_data,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [adtm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [adtm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int PW   = adtm_pkg::PIX_W;
    localparam int LW   = 2 * PW;

    // Last index in use for a size value: zero acts as one, large values clamp
    function automatic int unsigned f_last_idx(input logic [adtm_pkg::SIZE_W-1:0] v,
                                               input int unsigned maxv);
        if (v == '0) begin
            return 0;
        end else if (int'(v) > maxv) begin
            return maxv - 1;
        end else begin
            return int'(v) - 1;
        end
    endfunction

    // Configuration
    logic                         cfg_wr;
    logic                         size_wr;
    logic [XW-1:0]                r_last_x;
    logic [YW-1:0]                r_last_y;
    logic [adtm_pkg::THR_W-1:0]   r_thr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign size_wr     = cfg_wr && ((i_cfg_index == adtm_pkg::CFG_FRAME_WIDTH) ||
                                    (i_cfg_index == adtm_pkg::CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= XW'(f_last_idx(adtm_pkg::SIZE_RESET, MAX_WIDTH));
            r_last_y <= YW'(f_last_idx(adtm_pkg::SIZE_RESET, MAX_HEIGHT));
            r_thr    <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                adtm_pkg::CFG_FRAME_WIDTH: begin
                    r_last_x <= XW'(f_last_idx(i_cfg_data, MAX_WIDTH));
                end
                adtm_pkg::CFG_FRAME_HEIGHT: begin
                    r_last_y <= YW'(f_last_idx(i_cfg_data, MAX_HEIGHT));
                end
                adtm_pkg::CFG_DIFF_THRESHOLD: begin
                    r_thr <= i_cfg_data[adtm_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake
    logic in_acc;
    logic a_adv;
    logic grp_free;
    logic r_a_vld;

    assign a_adv      = r_a_vld && grp_free;
    assign o_in_stall = r_a_vld && !a_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Position of the next input pixel
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (size_wr) begin
            r_x <= '0;
            r_y <= '0;
        end else if (in_acc) begin
            if (r_x == r_last_x) begin
                r_x <= '0;
                r_y <= (r_y == r_last_y) ? '0 : r_y + YW'(1);
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
    end

    // Stage A: pixel, its position and the line memory word
    adtm_pkg::t_in_beat r_a_pix;
    logic [XW-1:0]      r_a_x;
    logic [YW-1:0]      r_a_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (in_acc) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_pix <= i_in_data;
            r_a_x   <= r_x;
            r_a_y   <= r_y;
        end
    end

    // Line memory word: [2*PW-1:PW] two rows above, [PW-1:0] row above
    logic [LW-1:0] mem_rdata;
    logic [LW-1:0] line_word;
    logic [LW-1:0] wr_word;

    adtm_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (LW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (a_adv),
        .i_wr_addr (r_a_x),
        .i_wr_data (wr_word),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_x),
        .o_rd_data (mem_rdata)
    );

    // Last write, forwarded when a one-pixel row reads the column just written
    logic          r_fwd_vld;
    logic [XW-1:0] r_fwd_addr;
    logic [LW-1:0] r_fwd_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (a_adv) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_fwd_addr <= r_a_x;
            r_fwd_word <= wr_word;
        end
    end

    assign line_word = (r_fwd_vld && (r_fwd_addr == r_a_x)) ? r_fwd_word : mem_rdata;

    // Difference, threshold and column minima
    logic [PW-1:0]  above_raw;
    logic [PW-1:0]  two_raw;
    logic [PW-1:0]  abs_diff;
    logic [PW-1:0]  d;
    logic [PW-1:0]  a;
    logic [PW-1:0]  b;
    logic [PW-1:0]  cp;
    logic [PW-1:0]  cl;
    logic           x_first;
    logic           x_last;
    logic           y_last;
    logic           y_ge1;

    assign above_raw = line_word[PW-1:0];
    assign two_raw   = line_word[LW-1:PW];
    assign abs_diff  = (r_a_pix.current_pixel >= r_a_pix.reference_pixel)
                     ? r_a_pix.current_pixel - r_a_pix.reference_pixel
                     : r_a_pix.reference_pixel - r_a_pix.current_pixel;
    assign d         = ({1'b0, abs_diff} < r_thr) ? '0 : abs_diff;
    assign y_ge1     = (r_a_y != '0);
    assign a         = y_ge1 ? above_raw : d;
    assign b         = (r_a_y > YW'(1)) ? two_raw : a;
    assign cp        = adtm_pkg::min8(adtm_pkg::min8(b, a), d);
    assign cl        = adtm_pkg::min8(a, d);
    assign wr_word   = {above_raw, d};
    assign x_first   = (r_a_x == '0);
    assign x_last    = (r_a_x == r_last_x);
    assign y_last    = (r_a_y == r_last_y);

    // Column minima window: [0..2] row above, [3..5] this row, oldest first
    logic [5:0][PW-1:0] r_win;
    logic [5:0][PW-1:0] n_win;

    always_comb begin
        if (x_first) begin
            n_win = {cl, cl, cl, cp, cp, cp};
        end else begin
            n_win = {cl, r_win[5], r_win[4], cp, r_win[2], r_win[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_adv) begin
            r_win <= n_win;
        end
    end

    // Results released by this pixel
    adtm_pkg::t_grp grp;
    logic [PW-1:0]  m_up;
    logic [PW-1:0]  m_cur;

    assign m_up  = adtm_pkg::min8(n_win[1], n_win[2]);
    assign m_cur = adtm_pkg::min8(n_win[4], n_win[5]);

    always_comb begin
        grp.mask    = {y_last && x_last, y_last && !x_first,
                       y_ge1 && x_last, y_ge1 && !x_first};
        grp.vals[0] = adtm_pkg::min8(n_win[0], m_up);
        grp.vals[1] = m_up;
        grp.vals[2] = adtm_pkg::min8(n_win[3], m_cur);
        grp.vals[3] = m_cur;
        grp.row     = adtm_pkg::COORD_W'(r_a_y);
        grp.col     = adtm_pkg::COORD_W'(r_a_x);
    end

    adtm_result_queue u_result_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (a_adv),
        .i_grp       (grp),
        .o_free      (grp_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
